// File: hw/rtl/mfmt_pkg.sv
// Package for the motor feedback multi-turn tracker.
// Holds the transaction payload types, the slot state entry and shared constants.
// No dependencies.
package mfmt_pkg;

  // First feedback identifier; identifiers above it select the following slots.
  localparam logic [10:0] FIRST_ID = 11'h201;

  // Width of the slot kind map and the number of slots it can describe.
  localparam int unsigned KIND_MAP_W = 44;
  localparam int unsigned MAP_SLOTS  = KIND_MAP_W / 2;

  // Reset values of the configuration registers.
  localparam logic [12:0] WRAP_THRESHOLD_RST    = 13'd5500;
  localparam logic [14:0] FEEDER_TURN_LIMIT_RST = 15'd10000;

  // Depth of the result queue in front of the output port.
  localparam int unsigned OUT_FIFO_DEPTH = 8;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SLOT_KIND_MAP     = 2'd0,
    CFG_WRAP_THRESHOLD    = 2'd1,
    CFG_FEEDER_TURN_LIMIT = 2'd2
  } mfmt_cfg_e;

  // Slot kinds as coded in the kind map.
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_RAW    = 2'd1,
    KIND_GIMBAL = 2'd2,
    KIND_FEEDER = 2'd3
  } mfmt_kind_e;

  // One feedback frame.
  typedef struct packed {
    logic       bus_select;
    logic [10:0] frame_id;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] byte6;
  } mfmt_in_t;

  // One tracker result.
  typedef struct packed {
    logic               handled;
    logic [4:0]         slot_index;
    logic [15:0]        raw_angle;
    logic signed [15:0] speed_value;
    logic signed [15:0] current_value;
    logic [7:0]         temperature;
    logic signed [15:0] turn_count;
    logic signed [31:0] position_counts;
    logic signed [15:0] reference_adjust_turns;
    logic signed [31:0] initial_offset_counts;
  } mfmt_out_t;

  // Per-slot state word kept in the slot RAM. The feeder offset is kept as the
  // turn count and angle it was taken from and is expanded on the way out.
  typedef struct packed {
    logic [15:0]        prev_angle;
    logic signed [15:0] turns;
    logic               offset_taken;
    logic signed [15:0] offset_turns;
    logic [15:0]        offset_angle;
  } mfmt_entry_t;

endpackage

// File: hw/rtl/motor_feedback_multiturn_tracker_top.sv
// Motor feedback multi-turn tracker: maps feedback frames to motor slots, unpacks
// them and keeps a per-slot turn count. Takes one frame every clock cycle; input
// stalls only when the eight-entry output queue, counting frames still in the
// pipeline, is full. The result of a frame passes the pipeline registers before it
// enters the output queue. Slot state lives in one RAM that is read when a frame is
// taken and written back in the following cycle, with the word being written
// forwarded to a frame that follows directly. Each slot has a valid flop cleared by
// reset, so the block is usable right after reset with no clearing pass.
// Depends on mfmt_pkg, mfmt_ram and mfmt_out_fifo.
module motor_feedback_multiturn_tracker_top #(
  parameter int unsigned SLOTS_PER_BUS   = 11,
  parameter int unsigned BUS_COUNT       = 2,
  parameter int unsigned COUNTS_PER_TURN = 8192
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [43:0]         cfg_wdata_i,
  // Frame input.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mfmt_pkg::mfmt_in_t  in_data_i,
  // Result output.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mfmt_pkg::mfmt_out_t out_data_o
);

  import mfmt_pkg::*;

  localparam int unsigned TOTAL_SLOTS = SLOTS_PER_BUS * BUS_COUNT;
  localparam int unsigned AW          = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int unsigned FPW         = $clog2(OUT_FIFO_DEPTH);
  localparam logic [10:0] ID_END      = 11'(FIRST_ID + SLOTS_PER_BUS);
  localparam logic signed [17:0] CPT_S = 18'(COUNTS_PER_TURN);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [KIND_MAP_W-1:0] kind_map_q;
  logic [12:0]           wrap_thr_q;
  logic [14:0]           turn_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_map_q <= '0;
      wrap_thr_q <= WRAP_THRESHOLD_RST;
      turn_lim_q <= FEEDER_TURN_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SLOT_KIND_MAP:     kind_map_q <= cfg_wdata_i;
        CFG_WRAP_THRESHOLD:    wrap_thr_q <= cfg_wdata_i[12:0];
        CFG_FEEDER_TURN_LIMIT: turn_lim_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Frame decode and slot RAM read
  // ---------------------------------------------------------------------------
  logic            in_accept;
  logic            id_ok, bus_ok, slot_ok, dec_handled;
  logic [4:0]      mslot, dec_slot;
  logic [5:0]      kind_pos;
  mfmt_kind_e      dec_kind;
  logic [AW-1:0]   rd_addr;

  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    id_ok    = (in_data_i.frame_id >= FIRST_ID) && (in_data_i.frame_id < ID_END);
    mslot    = 5'(in_data_i.frame_id - FIRST_ID);
    dec_slot = in_data_i.bus_select ? (mslot + 5'(SLOTS_PER_BUS)) : mslot;
    bus_ok   = (32'(in_data_i.bus_select) < BUS_COUNT);
    slot_ok  = (32'(dec_slot) < TOTAL_SLOTS) && (32'(dec_slot) < MAP_SLOTS);
    kind_pos = {dec_slot, 1'b0};
    dec_kind = KIND_NONE;
    if (slot_ok) begin
      dec_kind = mfmt_kind_e'(kind_map_q[kind_pos +: 2]);
    end
    dec_handled = id_ok && bus_ok && slot_ok && (dec_kind != KIND_NONE);
    rd_addr     = AW'(dec_slot);
  end

  // ---------------------------------------------------------------------------
  // Pipeline registers
  // ---------------------------------------------------------------------------
  logic               s1_v_q, s2_v_q, s3_v_q;
  logic               s1_handled_q, s2_handled_q, s3_handled_q;
  mfmt_kind_e         s1_kind_q;
  logic [4:0]         s1_slot_q, s2_slot_q, s3_slot_q;
  logic [AW-1:0]      s1_addr_q, s2_addr_q;
  mfmt_in_t           s1_in_q, s2_in_q, s3_in_q;
  logic               s1_ent_vld_q;
  logic               s2_wr_q;
  mfmt_entry_t        s2_ent_q;
  logic signed [15:0] s2_turns_q, s3_turns_q;
  logic signed [15:0] s2_adj_q, s3_adj_q;
  logic               s2_pos_en_q, s3_pos_en_q;
  logic               s2_off_en_q, s3_off_en_q;
  logic signed [31:0] s3_prod_q, s3_oprod_q;
  logic [15:0]        s3_oangle_q;

  logic [TOTAL_SLOTS-1:0] ent_vld_q;
  logic                   ram_we;
  mfmt_entry_t            ram_rdata, new_ent;

  mfmt_ram #(
    .WIDTH ($bits(mfmt_entry_t)),
    .DEPTH (TOTAL_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (new_ent),
    .re_i    (in_accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: forward, count turns, build the write-back word
  // ---------------------------------------------------------------------------
  logic               fwd;
  mfmt_entry_t        base;
  logic signed [16:0] diff, thr_s, lim_s, turns_x;
  logic signed [15:0] turns_new, adj_new;
  logic               is_track, is_feeder;

  always_comb begin
    // The word written by the frame just ahead is not yet visible in the RAM.
    fwd  = s2_v_q && s2_wr_q && (s2_addr_q == s1_addr_q);
    base = fwd ? s2_ent_q : (s1_ent_vld_q ? ram_rdata : '0);

    is_track  = (s1_kind_q == KIND_GIMBAL) || (s1_kind_q == KIND_FEEDER);
    is_feeder = (s1_kind_q == KIND_FEEDER);

    // Jump against the previous angle decides a turn up or down.
    diff  = $signed({1'b0, s1_in_q.byte0, s1_in_q.byte1}) - $signed({1'b0, base.prev_angle});
    thr_s = $signed({4'b0, wrap_thr_q});
    if (diff < -thr_s) begin
      turns_new = base.turns + 16'sd1;
    end else if (diff > thr_s) begin
      turns_new = base.turns - 16'sd1;
    end else begin
      turns_new = base.turns;
    end

    // Feeder count beyond the limit is dropped and reported as an adjustment.
    adj_new = '0;
    lim_s   = $signed({2'b0, turn_lim_q});
    turns_x = 17'(turns_new);
    if (is_feeder && ((turns_x > lim_s) || (turns_x < -lim_s))) begin
      adj_new   = 16'sd0 - turns_new;
      turns_new = '0;
    end

    // Write-back word.
    new_ent            = base;
    new_ent.prev_angle = {s1_in_q.byte0, s1_in_q.byte1};
    if (is_track) begin
      new_ent.turns = turns_new;
    end
    if (is_feeder && !base.offset_taken) begin
      new_ent.offset_taken = 1'b1;
      new_ent.offset_turns = turns_new;
      new_ent.offset_angle = {s1_in_q.byte0, s1_in_q.byte1};
    end

    ram_we = s1_v_q && s1_handled_q;
  end

  // Slot valid flops: a slot never written reads as all zeros.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (ram_we) begin
      ent_vld_q[s1_addr_q] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: scale turn counts to encoder counts
  // ---------------------------------------------------------------------------
  logic signed [33:0] prod, oprod;

  always_comb begin
    prod  = s2_turns_q * CPT_S;
    oprod = s2_ent_q.offset_turns * CPT_S;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: add the angle and build the result
  // ---------------------------------------------------------------------------
  mfmt_out_t res;

  always_comb begin
    res = '0;
    if (s3_handled_q) begin
      res.handled                = 1'b1;
      res.slot_index             = s3_slot_q;
      res.raw_angle              = {s3_in_q.byte0, s3_in_q.byte1};
      res.speed_value            = {s3_in_q.byte2, s3_in_q.byte3};
      res.current_value          = {s3_in_q.byte4, s3_in_q.byte5};
      res.temperature            = s3_in_q.byte6;
      res.turn_count             = s3_turns_q;
      res.reference_adjust_turns = s3_adj_q;
      if (s3_pos_en_q) begin
        res.position_counts = s3_prod_q + $signed({16'b0, s3_in_q.byte0, s3_in_q.byte1});
      end
      if (s3_off_en_q) begin
        res.initial_offset_counts = s3_oprod_q + $signed({16'b0, s3_oangle_q});
      end
    end
  end

  // Pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_accept;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_handled_q <= dec_handled;
      s1_kind_q    <= dec_kind;
      s1_slot_q    <= dec_slot;
      s1_addr_q    <= rd_addr;
      s1_in_q      <= in_data_i;
      s1_ent_vld_q <= dec_handled ? ent_vld_q[rd_addr] : 1'b0;
    end
    s2_handled_q <= s1_handled_q;
    s2_wr_q      <= s1_v_q && s1_handled_q;
    s2_slot_q    <= s1_slot_q;
    s2_addr_q    <= s1_addr_q;
    s2_in_q      <= s1_in_q;
    s2_ent_q     <= new_ent;
    s2_turns_q   <= is_track ? turns_new : '0;
    s2_adj_q     <= adj_new;
    s2_pos_en_q  <= is_track;
    s2_off_en_q  <= is_feeder;

    s3_handled_q <= s2_handled_q;
    s3_slot_q    <= s2_slot_q;
    s3_in_q      <= s2_in_q;
    s3_turns_q   <= s2_turns_q;
    s3_adj_q     <= s2_adj_q;
    s3_pos_en_q  <= s2_pos_en_q;
    s3_off_en_q  <= s2_off_en_q;
    s3_prod_q    <= prod[31:0];
    s3_oprod_q   <= oprod[31:0];
    s3_oangle_q  <= s2_ent_q.offset_angle;
  end

  // ---------------------------------------------------------------------------
  // Output queue and input flow control
  // ---------------------------------------------------------------------------
  logic [FPW:0]   fifo_cnt;
  logic [FPW+1:0] occupancy;

  mfmt_out_fifo #(
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s3_v_q),
    .data_i  (res),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o),
    .count_o (fifo_cnt)
  );

  // Every frame in the pipeline already holds a queue place.
  assign occupancy = (FPW+2)'(fifo_cnt) + (FPW+2)'(s1_v_q) + (FPW+2)'(s2_v_q)
                   + (FPW+2)'(s3_v_q);
  assign in_stall_o = (occupancy >= (FPW+2)'(OUT_FIFO_DEPTH));

`ifndef SYNTH
  // Frames in flight never outnumber the queue places.
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy <= (FPW+2)'(OUT_FIFO_DEPTH))
    else $error("tracker: more frames in flight than output queue places");

  // A taken frame reaches the state update stage in the next cycle.
  a_accept_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_v_q)
    else $error("tracker: accepted frame lost before stage one");

  // A slot written back is marked valid from then on.
  a_slot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> ent_vld_q[$past(s1_addr_q)])
    else $error("tracker: written slot not marked valid");
`endif

endmodule

// File: hw/rtl/mfmt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mfmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the address written in the same cycle returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/mfmt_out_fifo.sv
// Result queue between the tracker pipeline and the output port.
// Depends on mfmt_pkg for the result payload type.
module mfmt_out_fifo #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mfmt_pkg::mfmt_out_t data_i,
  output logic                valid_o,
  input  logic                stall_i,
  output mfmt_pkg::mfmt_out_t data_o,
  output logic [PW:0]         count_o
);

  import mfmt_pkg::*;

  mfmt_out_t   mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;
  assign pop     = valid_o && !stall_i;

  // Pointer and count update; the producer never pushes into a full queue.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + (PW+1)'(push_i) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: tb/sv/motor_feedback_multiturn_tracker_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the motor feedback multi-turn tracker.
// A scoreboard class predicts each result from the accepted frames and checks it.
// Depends on mfmt_pkg and motor_feedback_multiturn_tracker_top.
module motor_feedback_multiturn_tracker_top_tb;
  import mfmt_pkg::*;

  localparam int SLOTS_PER_BUS    = 11;
  localparam int BUS_COUNT        = 2;
  localparam int TOTAL_SLOTS      = SLOTS_PER_BUS * BUS_COUNT;
  localparam int COUNTS_PER_TURN  = 8192;
  localparam int RANDOM_PER_PHASE = 642;
  localparam int HOLD_CYCLES      = 300;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int DRAIN_CYCLES     = 16;

  // Predicts the tracker result of every accepted frame and checks the results in order.
  class tracker_scoreboard;
    logic [43:0]        kind_map;
    logic [12:0]        jump_limit;
    logic [14:0]        turn_cap;
    logic [15:0]        seen_angle [TOTAL_SLOTS];
    logic signed [15:0] turn_cnt [TOTAL_SLOTS];
    bit                 offset_valid [TOTAL_SLOTS];
    logic signed [31:0] offset_pos [TOTAL_SLOTS];
    mfmt_out_t          pending_results [$];
    int unsigned        errors, frames, checked, handled, turn_events, overflows, wraps;

    function new();
      kind_map   = '0;
      jump_limit = WRAP_THRESHOLD_RST;
      turn_cap   = FEEDER_TURN_LIMIT_RST;
      foreach (seen_angle[s]) begin
        seen_angle[s]   = '0;
        turn_cnt[s]     = '0;
        offset_valid[s] = 1'b0;
        offset_pos[s]   = '0;
      end
    endfunction

    function void write_reg(mfmt_cfg_e idx, logic [43:0] v);
      case (idx)
        CFG_SLOT_KIND_MAP:     kind_map = v;
        CFG_WRAP_THRESHOLD:    jump_limit = v[12:0];
        CFG_FEEDER_TURN_LIMIT: turn_cap = v[14:0];
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted frame and updates the slot state.
    function void note_frame(mfmt_in_t f);
      mfmt_out_t          r;
      mfmt_kind_e         k;
      logic signed [15:0] t16;
      int                 id, first, s, ang, prev, diff, t, pos, thr, lim;
      r     = '0;
      first = FIRST_ID;
      id    = f.frame_id;
      ang   = {f.byte0, f.byte1};
      frames++;
      if (id >= first && id < first + SLOTS_PER_BUS) begin
        s = (f.bus_select ? SLOTS_PER_BUS : 0) + (id - first);
        k = mfmt_kind_e'(kind_map[2*s +: 2]);
        if (k != KIND_NONE) begin
          handled++;
          r.handled       = 1'b1;
          r.slot_index    = s[4:0];
          r.raw_angle     = ang[15:0];
          r.speed_value   = {f.byte2, f.byte3};
          r.current_value = {f.byte4, f.byte5};
          r.temperature   = f.byte6;
          if (k != KIND_RAW) begin
            thr  = jump_limit;
            lim  = turn_cap;
            prev = seen_angle[s];
            diff = ang - prev;
            t    = turn_cnt[s];
            // A large backward jump means the encoder passed zero going forward.
            if (diff < -thr) begin
              t++;
              turn_events++;
            end else if (diff > thr) begin
              t--;
              turn_events++;
            end
            if (t > 32767 || t < -32768) wraps++;
            t16 = t[15:0];
            t   = t16;
            // Feeder counts past the limit are cleared and the removed amount reported.
            if (k == KIND_FEEDER && (t > lim || t < -lim)) begin
              overflows++;
              r.reference_adjust_turns = -t16;
              t   = 0;
              t16 = '0;
            end
            pos = t * COUNTS_PER_TURN + ang;
            if (k == KIND_FEEDER) begin
              if (!offset_valid[s]) begin
                offset_pos[s]   = pos;
                offset_valid[s] = 1'b1;
              end
              r.initial_offset_counts = offset_pos[s];
            end
            turn_cnt[s]       = t16;
            r.turn_count      = t16;
            r.position_counts = pos;
          end
          seen_angle[s] = ang[15:0];
        end
      end
      pending_results.push_back(r);
    endfunction

    function void cmp_field(string name, logic signed [32:0] e, logic signed [32:0] a);
      if (a !== e) begin
        errors++;
        $error("%s mismatch: expected %0d, actual %0d", name, e, a);
      end
    endfunction

    // Compares one accepted result with the oldest pending prediction.
    function void check_result(mfmt_out_t a);
      mfmt_out_t e;
      checked++;
      if (pending_results.size() == 0) begin
        errors++;
        $error("result for slot %0d arrived with no frame pending", a.slot_index);
      end else begin
        e = pending_results.pop_front();
        cmp_field("handled", e.handled, a.handled);
        cmp_field("slot_index", e.slot_index, a.slot_index);
        cmp_field("raw_angle", e.raw_angle, a.raw_angle);
        cmp_field("speed_value", e.speed_value, a.speed_value);
        cmp_field("current_value", e.current_value, a.current_value);
        cmp_field("temperature", e.temperature, a.temperature);
        cmp_field("turn_count", e.turn_count, a.turn_count);
        cmp_field("position_counts", e.position_counts, a.position_counts);
        cmp_field("reference_adjust_turns", e.reference_adjust_turns,
                  a.reference_adjust_turns);
        cmp_field("initial_offset_counts", e.initial_offset_counts,
                  a.initial_offset_counts);
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [43:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  mfmt_in_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  mfmt_out_t   out_data_o;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int          hold_left     = 0;
  int          quiet_cycles  = 0;

  tracker_scoreboard sb = new();

  motor_feedback_multiturn_tracker_top #(
    .SLOTS_PER_BUS  (SLOTS_PER_BUS),
    .BUS_COUNT      (BUS_COUNT),
    .COUNTS_PER_TURN(COUNTS_PER_TURN)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result side: random stalls, or a long hold-off when the stimulus asks for one.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check every result transaction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Give up when neither channel has moved for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("motor_feedback_multiturn_tracker_top_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic mfmt_in_t frame_of(bit bus, logic [10:0] id, logic [15:0] ang,
                                        logic [15:0] spd, logic [15:0] cur,
                                        logic [7:0] temp);
    mfmt_in_t f;
    f.bus_select = bus;
    f.frame_id   = id;
    {f.byte0, f.byte1} = ang;
    {f.byte2, f.byte3} = spd;
    {f.byte4, f.byte5} = cur;
    f.byte6 = temp;
    return f;
  endfunction

  // Frame for a motor slot with the given angle and random speed, current and temperature.
  function automatic mfmt_in_t slot_frame(bit bus, int mslot, logic [15:0] ang);
    logic [31:0] r;
    r = $urandom;
    return frame_of(bus, FIRST_ID + mslot[10:0], ang, r[15:0], r[31:16],
                    8'($urandom));
  endfunction

  function automatic logic [43:0] random_kind_map();
    logic [43:0] m;
    int          r;
    for (int s = 0; s < TOTAL_SLOTS; s++) begin
      r = $urandom_range(99);
      m[2*s +: 2] = (r < 10) ? KIND_NONE : (r < 30) ? KIND_RAW :
                    (r < 65) ? KIND_GIMBAL : KIND_FEEDER;
    end
    return m;
  endfunction

  // Mostly in-range identifiers; angles near the last one, within a turn, or anywhere.
  function automatic mfmt_in_t random_frame();
    int          pick, mslot, s;
    logic [10:0] id;
    bit          bus;
    logic [15:0] ang;
    logic [31:0] r;
    bus   = 1'($urandom_range(1));
    mslot = $urandom_range(SLOTS_PER_BUS - 1);
    pick  = $urandom_range(99);
    if (pick < 85) id = FIRST_ID + mslot[10:0];
    else if (pick < 93) id = 11'($urandom_range(2047));
    else if (pick < 96) id = FIRST_ID - 11'd1;
    else id = FIRST_ID + 11'(SLOTS_PER_BUS);
    s    = (bus ? SLOTS_PER_BUS : 0) + mslot;
    pick = $urandom_range(99);
    if (pick < 50) ang = 16'(sb.seen_angle[s] + $urandom_range(18000) - 9000);
    else if (pick < 75) ang = 16'($urandom_range(COUNTS_PER_TURN - 1));
    else ang = 16'($urandom_range(65535));
    r = $urandom;
    return frame_of(bus, id, ang, r[15:0], r[31:16], 8'($urandom));
  endfunction

  // Offers one frame and returns at the falling edge after it was taken.
  // Valid stays high so that a following frame goes out back to back.
  task automatic send_frame(input mfmt_in_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = f;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_frame(f);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input mfmt_cfg_e idx, input logic [43:0] v);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.write_reg(idx, v);
  endtask

  // Stops offering frames until every predicted result has been seen.
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [43:0] m;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset wrap threshold with a small feeder limit.
    m = '0;
    m[1:0]   = KIND_RAW;
    m[3:2]   = KIND_GIMBAL;
    m[5:4]   = KIND_FEEDER;
    m[21:20] = KIND_FEEDER;
    m[43:42] = KIND_GIMBAL;
    write_reg(CFG_SLOT_KIND_MAP, m);
    write_reg(CFG_FEEDER_TURN_LIMIT, 44'd2);
    // Identifiers out of range and an unregistered slot.
    send_frame(frame_of(1'b0, FIRST_ID - 11'd1, 16'h1234, 16'h0001, 16'hFFFF, 8'h55));
    send_frame(frame_of(1'b1, FIRST_ID + 11'd11, 16'h4321, 16'h8000, 16'h7FFF, 8'hAA));
    send_frame(frame_of(1'b1, 11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_frame(frame_of(1'b0, 11'h000, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    send_frame(slot_frame(1'b0, 3, 16'd777));
    // Raw-only slot with extreme payloads.
    send_frame(frame_of(1'b0, FIRST_ID, 16'hFFFF, 16'h8000, 16'h7FFF, 8'hFF));
    send_frame(frame_of(1'b0, FIRST_ID, 16'h0000, 16'h7FFF, 16'h8000, 8'h00));
    // First feeder frame latches the offset.
    send_frame(slot_frame(1'b0, 2, 16'd1000));
    // Gimbal turns down, up, and down on a full-range angle.
    send_frame(slot_frame(1'b0, 1, 16'd8191));
    send_frame(slot_frame(1'b0, 1, 16'd100));
    send_frame(slot_frame(1'b0, 1, 16'hFFFF));
    // Jumps exactly at the threshold do not count; one past it does.
    send_frame(slot_frame(1'b1, 10, 16'd0));
    send_frame(slot_frame(1'b1, 10, 16'd5500));
    send_frame(slot_frame(1'b1, 10, 16'd0));
    send_frame(slot_frame(1'b1, 10, 16'd5501));
    // Feeder overflow going down, then going up.
    send_frame(slot_frame(1'b0, 2, 16'd7000));
    send_frame(slot_frame(1'b0, 2, 16'd13000));
    send_frame(slot_frame(1'b0, 2, 16'd19000));
    send_frame(slot_frame(1'b0, 2, 16'd13000));
    send_frame(slot_frame(1'b0, 2, 16'd7000));
    send_frame(slot_frame(1'b0, 2, 16'd1000));
    // First frame of another feeder comes with a turn already counted.
    send_frame(slot_frame(1'b0, 10, 16'd50000));

    // Random part in three stall patterns, each with its own settings.
    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 77;
          write_reg(CFG_SLOT_KIND_MAP, random_kind_map());
          write_reg(CFG_WRAP_THRESHOLD, 44'($urandom_range(7000, 1000)));
          write_reg(CFG_FEEDER_TURN_LIMIT, 44'($urandom_range(6)));
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 13;
          write_reg(CFG_SLOT_KIND_MAP, 44'hFFF_FFFF_FFFF);
          write_reg(CFG_WRAP_THRESHOLD, 44'd8191);
          write_reg(CFG_FEEDER_TURN_LIMIT, 44'd1);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_reg(CFG_SLOT_KIND_MAP, random_kind_map());
          write_reg(CFG_WRAP_THRESHOLD, 44'd0);
          write_reg(CFG_FEEDER_TURN_LIMIT, 44'($urandom_range(40, 3)));
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Hold the result side off long enough for the block to back up.
        if (n == 200 && phase != 1) hold_req = 1'b1;
        send_frame(random_frame());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Run covered %0d frames (%0d handled), %0d turn steps, %0d feeder overflows,",
             sb.frames, sb.handled, sb.turn_events, sb.overflows);
    $display("%0d count wraps and %0d checked results under three stall patterns.",
             sb.wraps, sb.checked);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("motor_feedback_multiturn_tracker_top_tb: PASS");
    end else begin
      $display("motor_feedback_multiturn_tracker_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: motor_feedback_multiturn_tracker_top.f
hw/rtl/mfmt_pkg.sv
hw/rtl/mfmt_ram.sv
hw/rtl/mfmt_out_fifo.sv
hw/rtl/motor_feedback_multiturn_tracker_top.sv
tb/sv/motor_feedback_multiturn_tracker_top_tb.sv
